FILE: hw/rtl/tilemap_autotile_classifier_assert.svh
// Assertion macros shared by the autotile classifier RTL.
`ifndef TILEMAP_AUTOTILE_CLASSIFIER_ASSERT_SVH
`define TILEMAP_AUTOTILE_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TAC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tac: implication check failed");

// Next-cycle implication, checked out of reset.
`define TAC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tac: next-cycle check failed");

`endif

FILE: hw/rtl/tac_pkg.sv
// Package: constants, types and helpers of the autotile classifier.
package tac_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(CELLS);

    localparam int COORD_W = 6;
    localparam int DIM_W   = 7;
    localparam int SC_W    = COORD_W + 2;   // coordinate with room for -2..65
    localparam int KIND_W  = 8;
    localparam int DATA_W  = 8;
    localparam int CLASS_W = 5;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

    // 5x5 window around the written cell
    localparam int WIN_SIDE  = 5;
    localparam int WIN_CELLS = WIN_SIDE * WIN_SIDE;
    localparam int WIN_IDX_W = $clog2(WIN_CELLS);
    localparam int WPOS_W    = $clog2(WIN_SIDE);
    localparam int NUM_TGT   = 5;
    localparam int TGT_W     = $clog2(NUM_TGT);

    typedef enum logic [1:0] {
        CMD_SET_KIND = 2'd0,
        CMD_SET_DATA = 2'd1,
        CMD_QUERY    = 2'd2
    } cmd_t;

    typedef enum logic [0:0] {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WIN,
        ST_DRAIN,
        ST_CLASS,
        ST_QOUT
    } state_t;

    // occupancy of a cell and its 8 neighbors
    typedef struct packed {
        logic self_occ;
        logic l;
        logic r;
        logic u;
        logic d;
        logic lu;
        logic ru;
        logic ld;
        logic rd;
    } nbr_t;

    localparam logic [CLASS_W-1:0] CLS_EMPTY        = 5'd0;
    localparam logic [CLASS_W-1:0] CLS_IN_RIGHT_DN  = 5'd1;
    localparam logic [CLASS_W-1:0] CLS_IN_LEFT_DN   = 5'd2;
    localparam logic [CLASS_W-1:0] CLS_IN_LEFT_UP   = 5'd3;
    localparam logic [CLASS_W-1:0] CLS_IN_RIGHT_UP  = 5'd4;
    localparam logic [CLASS_W-1:0] CLS_CENTER       = 5'd5;
    localparam logic [CLASS_W-1:0] CLS_LEFT_UP      = 5'd9;
    localparam logic [CLASS_W-1:0] CLS_LEFT_DN      = 5'd10;
    localparam logic [CLASS_W-1:0] CLS_RIGHT_UP     = 5'd11;
    localparam logic [CLASS_W-1:0] CLS_RIGHT_DN     = 5'd12;
    localparam logic [CLASS_W-1:0] CLS_DN_BORDER    = 5'd13;
    localparam logic [CLASS_W-1:0] CLS_UP_BORDER    = 5'd14;
    localparam logic [CLASS_W-1:0] CLS_LR_BORDER    = 5'd15;
    localparam logic [CLASS_W-1:0] CLS_LEFT_BORDER  = 5'd16;
    localparam logic [CLASS_W-1:0] CLS_RIGHT_BORDER = 5'd17;
    localparam logic [CLASS_W-1:0] CLS_UD_BORDER    = 5'd18;
    localparam logic [CLASS_W-1:0] CLS_RIGHT        = 5'd19;
    localparam logic [CLASS_W-1:0] CLS_LEFT         = 5'd20;
    localparam logic [CLASS_W-1:0] CLS_DOWN         = 5'd21;
    localparam logic [CLASS_W-1:0] CLS_UP           = 5'd22;
    localparam logic [CLASS_W-1:0] CLS_ROCK         = 5'd23;

    localparam logic [DATA_W-1:0] CENTER_VARIANTS = DATA_W'(4);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
        return ADDR_W'(ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x));
    endfunction

    // c is a two's complement coordinate; negative or >= dim is off the map
    function automatic logic in_map(input logic [SC_W-1:0] c,
                                    input logic [DIM_W-1:0] dim);
        return !c[SC_W-1] && (c[DIM_W-1:0] < dim);
    endfunction

endpackage

FILE: hw/rtl/tac_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tac_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DW-1:0]            wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DW-1:0]            rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/tac_classify.sv
// Shape classifier: maps 8-neighbor occupancy and data byte to a tile class.
module tac_classify (
    input  tac_pkg::nbr_t                      nbr,
    input  logic [tac_pkg::DATA_W-1:0]         data_byte,
    output logic [tac_pkg::CLASS_W-1:0]        tile_class
);
    import tac_pkg::*;

    logic l, r, u, d, lu, ru, ld, rd;

    always_comb
    begin
        l  = nbr.l;
        r  = nbr.r;
        u  = nbr.u;
        d  = nbr.d;
        lu = nbr.lu;
        ru = nbr.ru;
        ld = nbr.ld;
        rd = nbr.rd;
        priority if (!nbr.self_occ)
            tile_class = CLS_EMPTY;
        else if (l && r && u && d)
        begin
            priority if (!rd && lu && ru && ld)
                tile_class = CLS_IN_RIGHT_DN;
            else if (!ld && rd && ru && lu)
                tile_class = CLS_IN_LEFT_DN;
            else if (!lu && ru && rd && ld)
                tile_class = CLS_IN_LEFT_UP;
            else if (!ru && lu && rd && ld)
                tile_class = CLS_IN_RIGHT_UP;
            else if (data_byte < CENTER_VARIANTS)
                tile_class = CLASS_W'(CLS_CENTER + CLASS_W'(data_byte[1:0]));
            else
                tile_class = CLS_CENTER;
        end
        else if (!l && !u && d && r)
            tile_class = CLS_LEFT_UP;
        else if (!l && u && !d && r)
            tile_class = CLS_LEFT_DN;
        else if (l && !u && d && !r)
            tile_class = CLS_RIGHT_UP;
        else if (l && u && !d && !r)
            tile_class = CLS_RIGHT_DN;
        else if (!u && !l && d && !r)
            tile_class = CLS_DN_BORDER;
        else if (u && !l && !d && !r)
            tile_class = CLS_UP_BORDER;
        else if (u && !l && d && !r)
            tile_class = CLS_LR_BORDER;
        else if (!u && l && !d && !r)
            tile_class = CLS_LEFT_BORDER;
        else if (!u && !l && !d && r)
            tile_class = CLS_RIGHT_BORDER;
        else if (!u && l && !d && r)
            tile_class = CLS_UD_BORDER;
        else if (l && u && d)
            tile_class = CLS_RIGHT;
        else if (r && u && d)
            tile_class = CLS_LEFT;
        else if (u && l && r)
            tile_class = CLS_DOWN;
        else if (d && l && r)
            tile_class = CLS_UP;
        else
            tile_class = CLS_ROCK;
    end

endmodule

FILE: hw/rtl/tilemap_autotile_classifier.sv
// Top level: autotile classifier with tile map stores and edit sequencer.
//
// Input channel (valid/ready) carries cmd, x_coord, y_coord, value. Output
// channel (out_valid/out_ready) carries out_x, out_y, tile_class, last.
// Config channel (cfg_valid/cfg_ready, always ready) writes map_width (index 0)
// and map_height (index 1); write them only while the block is idle.
// Items addressing a cell outside the map in use, and cmd 3, are dropped.
// Set data: written on the take, no result.
// Query: the class is read from its RAM on the take and loaded into the output
// register once that is free; ready returns when the result is loaded.
// Set kind: the kind is written on accept, then a 5x5 kind window is read
// from the kind RAM one cell per cycle, then a drain state, then the shared
// classifier handles the cell, left, right, up and down neighbor one per cycle
// while the output register can take each result.
// Results go through one output register; the sequencer waits while it is
// full and not taken, so a stalled receiver stalls the edit, never drops it.
// Reset starts a clearing pass over all 4096 cells that zeroes all three stores;
// ready stays low until it ends. Config writes are taken during it.
`include "tilemap_autotile_classifier_assert.svh"

module tilemap_autotile_classifier (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [tac_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          valid,
    output logic                          ready,
    input  logic [1:0]                    cmd,
    input  logic [tac_pkg::COORD_W-1:0]   x_coord,
    input  logic [tac_pkg::COORD_W-1:0]   y_coord,
    input  logic [tac_pkg::KIND_W-1:0]    value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tac_pkg::COORD_W-1:0]   out_x,
    output logic [tac_pkg::COORD_W-1:0]   out_y,
    output logic [tac_pkg::CLASS_W-1:0]   tile_class,
    output logic                          last
);
    import tac_pkg::*;

    // control registers
    state_t                 state_reg, state_next;
    logic [DIM_W-1:0]       map_width_reg, map_height_reg;
    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [WIN_IDX_W-1:0]   cnt_reg, cnt_next;
    logic [WPOS_W-1:0]      wx_reg, wx_next, wy_reg, wy_next;
    logic [TGT_W-1:0]       tgt_reg, tgt_next;
    logic                   rpend_reg, rinmap_reg;
    logic                   dpend_reg;
    logic [TGT_W-1:0]       dsel_reg;
    logic                   out_valid_reg, out_valid_next;

    // payload registers
    logic [COORD_W-1:0]     x_reg, y_reg;
    logic [WIN_CELLS-1:0]   win_reg;
    logic [DATA_W-1:0]      tdata_reg [NUM_TGT];
    logic [COORD_W-1:0]     out_x_reg, out_y_reg;
    logic [CLASS_W-1:0]     out_class_reg;
    logic                   out_last_reg;

    // RAM ports
    logic                   kind_we, kind_re, data_we, data_re, class_we, class_re;
    logic [ADDR_W-1:0]      kind_waddr, kind_raddr, data_waddr, data_raddr;
    logic [ADDR_W-1:0]      class_waddr, class_raddr;
    logic [KIND_W-1:0]      kind_wdata, kind_rdata;
    logic [DATA_W-1:0]      data_wdata, data_rdata;
    logic [CLASS_W-1:0]     class_wdata, class_rdata;

    logic [DIM_W-1:0]       eff_w, eff_h;
    logic                   in_acc, in_hit;
    logic [SC_W-1:0]        wcx, wcy;
    logic                   win_inmap;
    logic [SC_W-1:0]        tcx [NUM_TGT];
    logic [SC_W-1:0]        tcy [NUM_TGT];
    logic [NUM_TGT-1:0]     tgt_ok;
    logic [TGT_W-1:0]       dt;
    logic [WIN_IDX_W-1:0]   ctr;
    nbr_t                   nbr;
    logic [CLASS_W-1:0]     cls;
    logic                   out_load, rest_ok;

    tac_ram #(.DW(KIND_W), .DEPTH(CELLS)) u_kind_ram (
        .clk   (clk),
        .we    (kind_we),
        .waddr (kind_waddr),
        .wdata (kind_wdata),
        .re    (kind_re),
        .raddr (kind_raddr),
        .rdata (kind_rdata)
    );

    tac_ram #(.DW(DATA_W), .DEPTH(CELLS)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    tac_ram #(.DW(CLASS_W), .DEPTH(CELLS)) u_class_ram (
        .clk   (clk),
        .we    (class_we),
        .waddr (class_waddr),
        .wdata (class_wdata),
        .re    (class_re),
        .raddr (class_raddr),
        .rdata (class_rdata)
    );

    tac_classify u_classify (
        .nbr        (nbr),
        .data_byte  (tdata_reg[tgt_reg]),
        .tile_class (cls)
    );

    assign eff_w = (map_width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : map_width_reg;
    assign eff_h = (map_height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : map_height_reg;

    assign ready     = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = valid && ready;
    assign in_hit    = (DIM_W'(x_coord) < eff_w) && (DIM_W'(y_coord) < eff_h);

    assign out_valid  = out_valid_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign tile_class = out_class_reg;
    assign last       = out_last_reg;

    // window cell at offset (wx-2, wy-2) from the edited cell
    assign wcx       = SC_W'(x_reg) + SC_W'(wx_reg) - SC_W'(2);
    assign wcy       = SC_W'(y_reg) + SC_W'(wy_reg) - SC_W'(2);
    assign win_inmap = in_map(wcx, eff_w) && in_map(wcy, eff_h);

    // targets in result order: cell, left, right, up, down
    always_comb
    begin
        tcx[0] = SC_W'(x_reg);
        tcy[0] = SC_W'(y_reg);
        tcx[1] = SC_W'(x_reg) - SC_W'(1);
        tcy[1] = SC_W'(y_reg);
        tcx[2] = SC_W'(x_reg) + SC_W'(1);
        tcy[2] = SC_W'(y_reg);
        tcx[3] = SC_W'(x_reg);
        tcy[3] = SC_W'(y_reg) - SC_W'(1);
        tcx[4] = SC_W'(x_reg);
        tcy[4] = SC_W'(y_reg) + SC_W'(1);
        for (int i = 0; i < NUM_TGT; i++)
        begin
            tgt_ok[i] = in_map(tcx[i], eff_w) && in_map(tcy[i], eff_h);
        end
    end

    // window index of the current target's center
    always_comb
    begin
        unique case (tgt_reg)
            TGT_W'(1): ctr = WIN_IDX_W'(2 * WIN_SIDE + 1);
            TGT_W'(2): ctr = WIN_IDX_W'(2 * WIN_SIDE + 3);
            TGT_W'(3): ctr = WIN_IDX_W'(1 * WIN_SIDE + 2);
            TGT_W'(4): ctr = WIN_IDX_W'(3 * WIN_SIDE + 2);
            default:   ctr = WIN_IDX_W'(2 * WIN_SIDE + 2);
        endcase
        nbr.self_occ = win_reg[ctr];
        nbr.l        = win_reg[ctr - WIN_IDX_W'(1)];
        nbr.r        = win_reg[ctr + WIN_IDX_W'(1)];
        nbr.u        = win_reg[ctr - WIN_IDX_W'(WIN_SIDE)];
        nbr.d        = win_reg[ctr + WIN_IDX_W'(WIN_SIDE)];
        nbr.lu       = win_reg[ctr - WIN_IDX_W'(WIN_SIDE + 1)];
        nbr.ru       = win_reg[ctr - WIN_IDX_W'(WIN_SIDE - 1)];
        nbr.ld       = win_reg[ctr + WIN_IDX_W'(WIN_SIDE - 1)];
        nbr.rd       = win_reg[ctr + WIN_IDX_W'(WIN_SIDE + 1)];
    end

    // any in-map target still to come after the current one
    always_comb
    begin
        rest_ok = 1'b0;
        for (int i = 0; i < NUM_TGT; i++)
        begin
            if (TGT_W'(i) > tgt_reg)
            begin
                rest_ok = rest_ok | tgt_ok[i];
            end
        end
    end

    assign dt = cnt_reg[TGT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cnt_next       = cnt_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        tgt_next       = tgt_reg;
        out_load       = 1'b0;

        kind_we     = 1'b0;
        kind_waddr  = cell_addr(x_coord, y_coord);
        kind_wdata  = value;
        kind_re     = 1'b0;
        kind_raddr  = cell_addr(wcx[COORD_W-1:0], wcy[COORD_W-1:0]);
        data_we     = 1'b0;
        data_waddr  = cell_addr(x_coord, y_coord);
        data_wdata  = value;
        data_re     = 1'b0;
        data_raddr  = cell_addr(tcx[dt][COORD_W-1:0], tcy[dt][COORD_W-1:0]);
        class_we    = 1'b0;
        class_waddr = cell_addr(tcx[tgt_reg][COORD_W-1:0], tcy[tgt_reg][COORD_W-1:0]);
        class_wdata = cls;
        class_re    = 1'b0;
        class_raddr = cell_addr(x_coord, y_coord);

        unique case (state_reg)
            ST_CLEAR:
            begin
                kind_we     = 1'b1;
                data_we     = 1'b1;
                class_we    = 1'b1;
                kind_waddr  = clr_cnt_reg;
                data_waddr  = clr_cnt_reg;
                class_waddr = clr_cnt_reg;
                kind_wdata  = '0;
                data_wdata  = '0;
                class_wdata = CLS_EMPTY;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc && in_hit)
                begin
                    unique case (cmd_t'(cmd))
                        CMD_SET_KIND:
                        begin
                            kind_we    = 1'b1;
                            cnt_next   = '0;
                            wx_next    = '0;
                            wy_next    = '0;
                            state_next = ST_WIN;
                        end
                        CMD_SET_DATA:
                        begin
                            data_we = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            class_re   = 1'b1;
                            state_next = ST_QOUT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WIN:
            begin
                kind_re = win_inmap;
                // target data bytes ride along with the first NUM_TGT window reads
                if (cnt_reg < WIN_IDX_W'(NUM_TGT))
                begin
                    data_re = tgt_ok[dt];
                end
                cnt_next = cnt_reg + WIN_IDX_W'(1);
                if (wx_reg == WPOS_W'(WIN_SIDE - 1))
                begin
                    wx_next = '0;
                    wy_next = wy_reg + WPOS_W'(1);
                end
                else
                begin
                    wx_next = wx_reg + WPOS_W'(1);
                end
                if (cnt_reg == WIN_IDX_W'(WIN_CELLS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                tgt_next   = '0;
                state_next = ST_CLASS;
            end
            ST_CLASS:
            begin
                if (!tgt_ok[tgt_reg] || !out_valid_reg || out_ready)
                begin
                    if (tgt_ok[tgt_reg])
                    begin
                        class_we = 1'b1;
                        out_load = 1'b1;
                    end
                    if (tgt_reg == TGT_W'(NUM_TGT - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        tgt_next = tgt_reg + TGT_W'(1);
                    end
                end
            end
            ST_QOUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            map_width_reg  <= DIM_RESET;
            map_height_reg <= DIM_RESET;
            clr_cnt_reg    <= '0;
            cnt_reg        <= '0;
            wx_reg         <= '0;
            wy_reg         <= '0;
            tgt_reg        <= '0;
            rpend_reg      <= 1'b0;
            rinmap_reg     <= 1'b0;
            dpend_reg      <= 1'b0;
            dsel_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cnt_reg       <= cnt_next;
            wx_reg        <= wx_next;
            wy_reg        <= wy_next;
            tgt_reg       <= tgt_next;
            rpend_reg     <= (state_reg == ST_WIN);
            rinmap_reg    <= win_inmap;
            dpend_reg     <= data_re;
            dsel_reg      <= dt;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                    REG_MAP_HEIGHT: map_height_reg <= cfg_data;
                    default:        map_width_reg  <= map_width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg <= x_coord;
            y_reg <= y_coord;
        end
        // window bits shift in read order; first read ends at bit 0
        if (rpend_reg)
        begin
            win_reg <= {rinmap_reg && (kind_rdata != '0), win_reg[WIN_CELLS-1:1]};
        end
        if (dpend_reg)
        begin
            tdata_reg[dsel_reg] <= data_rdata;
        end
        if (out_load)
        begin
            if (state_reg == ST_QOUT)
            begin
                out_x_reg     <= x_reg;
                out_y_reg     <= y_reg;
                out_class_reg <= class_rdata;
                out_last_reg  <= 1'b1;
            end
            else
            begin
                out_x_reg     <= tcx[tgt_reg][COORD_W-1:0];
                out_y_reg     <= tcy[tgt_reg][COORD_W-1:0];
                out_class_reg <= cls;
                out_last_reg  <= !rest_ok;
            end
        end
    end

    `TAC_ASSERT_IMP(a_out_load_free, out_load, !out_valid_reg || out_ready)
    `TAC_ASSERT_IMP(a_class_wr_in_map, (state_reg == ST_CLASS) && class_we, tgt_ok[tgt_reg])
    `TAC_ASSERT_NXT(a_query_to_out, in_acc && in_hit && (cmd == CMD_QUERY), state_reg == ST_QOUT)

endmodule

FILE: test/tilemap_autotile_classifier_checker.sv
// Checker for the autotile classifier: tile map predictor and result scoreboard.
module tilemap_autotile_classifier_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [tac_pkg::DIM_W-1:0]     cfg_data,
    input  logic                          valid,
    input  logic                          ready,
    input  logic [1:0]                    cmd,
    input  logic [tac_pkg::COORD_W-1:0]   x_coord,
    input  logic [tac_pkg::COORD_W-1:0]   y_coord,
    input  logic [tac_pkg::KIND_W-1:0]    value,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [tac_pkg::COORD_W-1:0]   out_x,
    input  logic [tac_pkg::COORD_W-1:0]   out_y,
    input  logic [tac_pkg::CLASS_W-1:0]   tile_class,
    input  logic                          last,
    output int                            mismatches,
    output int                            results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import tac_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CLASS_W-1:0] cls;
        logic               last;
    } tile_result_t;

    logic [KIND_W-1:0]  kind_mem  [CELLS];
    logic [DATA_W-1:0]  data_mem  [CELLS];
    logic [CLASS_W-1:0] class_mem [CELLS];
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    tile_result_t       class_due [$];

    // register values above the map size act as the full size
    function automatic int clamp_dim(input logic [DIM_W-1:0] r, input int maxv);
        return (int'(r) > maxv) ? maxv : int'(r);
    endfunction

    function automatic logic occupied(input int x, input int y, input int w, input int h);
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 1'b0;
        return kind_mem[y * MAX_WIDTH + x] != '0;
    endfunction

    function automatic logic [CLASS_W-1:0] classify(input int x, input int y,
                                                    input int w, input int h);
        logic l, r, u, d, lu, ru, ld, rd;
        int   a;
        a = y * MAX_WIDTH + x;
        if (kind_mem[a] == '0)
            return CLS_EMPTY;
        l  = occupied(x - 1, y, w, h);
        r  = occupied(x + 1, y, w, h);
        u  = occupied(x, y - 1, w, h);
        d  = occupied(x, y + 1, w, h);
        lu = occupied(x - 1, y - 1, w, h);
        ru = occupied(x + 1, y - 1, w, h);
        ld = occupied(x - 1, y + 1, w, h);
        rd = occupied(x + 1, y + 1, w, h);
        if (l && r && u && d)
        begin
            if (!rd && lu && ru && ld) return CLS_IN_RIGHT_DN;
            if (!ld && rd && ru && lu) return CLS_IN_LEFT_DN;
            if (!lu && ru && rd && ld) return CLS_IN_LEFT_UP;
            if (!ru && lu && rd && ld) return CLS_IN_RIGHT_UP;
            if (data_mem[a] < CENTER_VARIANTS)
                return CLS_CENTER + CLASS_W'(data_mem[a]);
            return CLS_CENTER;
        end
        if (!l && !u && d && r) return CLS_LEFT_UP;
        if (!l && u && !d && r) return CLS_LEFT_DN;
        if (l && !u && d && !r) return CLS_RIGHT_UP;
        if (l && u && !d && !r) return CLS_RIGHT_DN;
        if (!u && !l && d && !r) return CLS_DN_BORDER;
        if (u && !l && !d && !r) return CLS_UP_BORDER;
        if (u && !l && d && !r) return CLS_LR_BORDER;
        if (!u && l && !d && !r) return CLS_LEFT_BORDER;
        if (!u && !l && !d && r) return CLS_RIGHT_BORDER;
        if (!u && l && !d && r) return CLS_UD_BORDER;
        if (l && u && d) return CLS_RIGHT;
        if (r && u && d) return CLS_LEFT;
        if (u && l && r) return CLS_DOWN;
        if (d && l && r) return CLS_UP;
        return CLS_ROCK;
    endfunction

    // updates the map and queues the classes the item reports
    function automatic void apply_map_edit(input logic [1:0] op,
                                           input logic [COORD_W-1:0] xc,
                                           input logic [COORD_W-1:0] yc,
                                           input logic [KIND_W-1:0] v);
        tile_result_t       res [NUM_TGT];
        logic [CLASS_W-1:0] cls;
        int                 w, h, xi, yi, nx, ny, n;
        w  = clamp_dim(width_reg, MAX_WIDTH);
        h  = clamp_dim(height_reg, MAX_HEIGHT);
        xi = int'(xc);
        yi = int'(yc);
        n  = 0;
        if (xi >= w || yi >= h)
            return;
        case (op)
            CMD_SET_DATA: data_mem[yi * MAX_WIDTH + xi] = v;
            CMD_QUERY:
            begin
                res[0] = tile_result_t'{xc, yc, class_mem[yi * MAX_WIDTH + xi], 1'b1};
                class_due = {class_due, res[0]};
            end
            CMD_SET_KIND:
            begin
                kind_mem[yi * MAX_WIDTH + xi] = v;
                // self, left, right, up, down
                for (int i = 0; i < NUM_TGT; i++)
                begin
                    nx = xi;
                    ny = yi;
                    case (i)
                        1: nx = xi - 1;
                        2: nx = xi + 1;
                        3: ny = yi - 1;
                        4: ny = yi + 1;
                        default: ;
                    endcase
                    if (nx >= 0 && ny >= 0 && nx < w && ny < h)
                    begin
                        cls = classify(nx, ny, w, h);
                        class_mem[ny * MAX_WIDTH + nx] = cls;
                        res[n] = tile_result_t'{COORD_W'(nx), COORD_W'(ny), cls, 1'b0};
                        n++;
                    end
                end
                res[n - 1].last = 1'b1;
                for (int i = 0; i < n; i++)
                    class_due = {class_due, res[i]};
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input int expv, input int got);
        if (expv != got)
        begin
            $error("%s: expected %0d, got %0d", name, expv, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tile_result_t exp_res;
        if (!rst_n)
        begin
            width_reg   = DIM_RESET;
            height_reg  = DIM_RESET;
            mismatches  = 0;
            results_due = 0;
            class_due.delete();
            for (int i = 0; i < CELLS; i++)
            begin
                kind_mem[i]  = '0;
                data_mem[i]  = '0;
                class_mem[i] = '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAP_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (valid && ready)
                apply_map_edit(cmd, x_coord, y_coord, value);
            if (out_valid && out_ready)
            begin
                if (class_due.size() == 0)
                begin
                    $error("unexpected result: x %0d y %0d class %0d last %0d",
                           out_x, out_y, tile_class, last);
                    mismatches++;
                end
                else
                begin
                    exp_res = class_due.pop_front();
                    check_field("out_x", exp_res.x, out_x);
                    check_field("out_y", exp_res.y, out_y);
                    check_field("tile_class", exp_res.cls, tile_class);
                    check_field("last", exp_res.last, last);
                end
            end
            results_due = class_due.size();
        end
    end

endmodule

FILE: test/tb.sv
// Testbench top: clock, reset, map edit stimulus and verdict for the autotile classifier.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tac_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [0:0]           cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 valid;
    logic                 ready;
    logic [1:0]           cmd;
    logic [COORD_W-1:0]   x_coord;
    logic [COORD_W-1:0]   y_coord;
    logic [KIND_W-1:0]    value;
    logic                 out_valid;
    logic                 out_ready;
    logic [COORD_W-1:0]   out_x;
    logic [COORD_W-1:0]   out_y;
    logic [CLASS_W-1:0]   tile_class;
    logic                 last;
    int                   mismatches;
    int                   results_due;

    int                   cur_w;
    int                   cur_h;
    int                   win_x;
    int                   win_y;
    int                   items_done;
    logic                 calm;

    tilemap_autotile_classifier i_dut (.*);

    tilemap_autotile_classifier_checker i_checker (.*);

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int draw_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // entered and left at a falling edge; valid stays high when the next item follows at once
    task automatic send_item(input logic [1:0] op, input int x, input int y, input int v);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd     <= op;
        x_coord <= COORD_W'(x);
        y_coord <= COORD_W'(y);
        value   <= KIND_W'(v);
        valid   <= 1'b1;
        @(posedge clk);
        while (!ready)
            @(posedge clk);
        @(negedge clk);
        if (op != CMD_UNUSED && x < cur_w && y < cur_h)
            items_done++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int data);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= DIM_W'(data);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_MAP_WIDTH)
            cur_w = (data > MAX_WIDTH) ? MAX_WIDTH : data;
        else
            cur_h = (data > MAX_HEIGHT) ? MAX_HEIGHT : data;
    endtask

    // drain all results, then give a dropped or data item time to finish
    task automatic settle();
        valid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic random_item();
        int         pick, x, y, v;
        logic [1:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            op = CMD_SET_KIND;
        else if (pick < 72)
            op = CMD_SET_DATA;
        else if (pick < 95)
            op = CMD_QUERY;
        else
            op = CMD_UNUSED;
        if ($urandom_range(0, 24) == 0)
            calm = ~calm;
        if ($urandom_range(0, 19) == 0)
        begin
            win_x = $urandom_range(0, (cur_w > 0) ? cur_w - 1 : 0);
            win_y = $urandom_range(0, (cur_h > 0) ? cur_h - 1 : 0);
        end
        if (cur_w == 0 || cur_h == 0 || $urandom_range(0, 6) == 0)
        begin
            x = $urandom_range(0, 63);
            y = $urandom_range(0, 63);
        end
        else
        begin
            x = (win_x + $urandom_range(0, 5)) % cur_w;
            y = (win_y + $urandom_range(0, 5)) % cur_h;
        end
        if (op == CMD_SET_KIND)
            v = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 255);
        else if (op == CMD_SET_DATA)
            v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
        else
            v = $urandom_range(0, 255);
        send_item(op, x, y, v);
    endtask

    // fill a 3x3 patch, set the center data, maybe knock out a diagonal, reclassify and query the center
    task automatic patch_item();
        int cx, cy;
        cx = $urandom_range(1, cur_w - 2);
        cy = $urandom_range(1, cur_h - 2);
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
                send_item(CMD_SET_KIND, cx + dx, cy + dy, $urandom_range(1, 255));
        send_item(CMD_SET_DATA, cx, cy, $urandom_range(0, 7));
        if ($urandom_range(0, 1) == 1)
            send_item(CMD_SET_KIND, cx + ($urandom_range(0, 1) ? 1 : -1),
                      cy + ($urandom_range(0, 1) ? 1 : -1), 0);
        send_item(CMD_SET_KIND, cx, cy, $urandom_range(1, 255));
        send_item(CMD_QUERY, cx, cy, 0);
    endtask

    task automatic run_phase(input int wv, input int hv, input int n);
        int target, sent;
        settle();
        write_reg(REG_MAP_WIDTH, wv);
        write_reg(REG_MAP_HEIGHT, hv);
        win_x  = 0;
        win_y  = 0;
        target = items_done + n;
        sent   = 0;
        while (items_done < target && sent < 8 * n)
        begin
            if (cur_w >= 3 && cur_h >= 3 && $urandom_range(0, 9) == 0)
            begin
                patch_item();
                sent += 12;
            end
            else
            begin
                random_item();
                sent++;
            end
        end
    endtask

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        valid      = 1'b0;
        cmd        = '0;
        x_coord    = '0;
        y_coord    = '0;
        value      = '0;
        cur_w      = MAX_WIDTH;
        cur_h      = MAX_HEIGHT;
        win_x      = 0;
        win_y      = 0;
        items_done = 0;
        calm       = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // fresh map, lone tiles at opposite corners, unknown command, then a 3x3 block
        send_item(CMD_QUERY, 0, 0, 0);
        send_item(CMD_SET_KIND, 0, 0, 1);
        send_item(CMD_SET_KIND, 63, 63, 255);
        send_item(CMD_SET_DATA, 63, 63, 255);
        send_item(CMD_UNUSED, 5, 5, 255);
        for (int yy = 10; yy <= 12; yy++)
            for (int xx = 10; xx <= 12; xx++)
                send_item(CMD_SET_KIND, xx, yy, 128);
        // center variants, oversized data byte, then an inner corner
        send_item(CMD_SET_DATA, 11, 11, 2);
        send_item(CMD_SET_KIND, 11, 11, 7);
        send_item(CMD_SET_DATA, 11, 11, 200);
        send_item(CMD_SET_KIND, 11, 11, 9);
        send_item(CMD_SET_KIND, 12, 12, 0);
        send_item(CMD_SET_KIND, 11, 11, 3);
        send_item(CMD_QUERY, 11, 11, 0);
        send_item(CMD_QUERY, 63, 63, 0);

        run_phase(127, 127, 32);
        run_phase(1, 1, 32);
        run_phase(5, 4, 32);
        run_phase(64, 1, 32);
        run_phase(0, 64, 6);
        run_phase(1, 64, 32);
        run_phase(64, 64, 32);
        run_phase(20, 33, 32);

        settle();
        if (mismatches == 0 && results_due == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tac_pkg.sv
hw/rtl/tac_ram.sv
hw/rtl/tac_classify.sv
hw/rtl/tilemap_autotile_classifier.sv
test/tilemap_autotile_classifier_checker.sv
test/tb.sv
